// ===== hw/rtl/c2dmac_pkg.sv =====
package c2dmac_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_HEIGHT     = 1024;

	localparam int SAMPLE_BITS   = 16;
	localparam int SUM_BITS      = 38;
	localparam int ROW_BITS      = 10;
	localparam int COL_OUT_BITS  = 10;
	localparam int DIM_BITS      = 11;
	localparam int KDIM_BITS     = 3;
	localparam int CIDX_BITS     = 6;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_IMG_WIDTH   = 2'd0,
		CFG_IMG_HEIGHT  = 2'd1,
		CFG_KERN_WIDTH  = 2'd2,
		CFG_KERN_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_COEF  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef struct packed {
		logic coef_wr;
		logic pix_wr;
		logic init;
		logic issue;
		logic next_row;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic                 emit;
		logic                 busy;
		logic                 out_blocked;
		logic [KDIM_BITS-1:0] kw;
		logic [KDIM_BITS-1:0] kh;
	} stat_t;

endpackage

// ===== hw/rtl/c2dmac_in_if.sv =====
interface c2dmac_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   operation;
	logic [c2dmac_pkg::CIDX_BITS-1:0]       coef_index;
	logic signed [c2dmac_pkg::SAMPLE_BITS-1:0] coef_value;
	logic signed [c2dmac_pkg::SAMPLE_BITS-1:0] pixel_value;

	modport source(output valid, output operation, output coef_index, output coef_value,
		output pixel_value, input ready);
	modport sink(input valid, input operation, input coef_index, input coef_value,
		input pixel_value, output ready);
endinterface

// ===== hw/rtl/c2dmac_out_if.sv =====
interface c2dmac_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [c2dmac_pkg::SUM_BITS-1:0]   conv_sum;
	logic [c2dmac_pkg::ROW_BITS-1:0]          out_row;
	logic [c2dmac_pkg::COL_OUT_BITS-1:0]      out_col;
	logic                                     frame_last;

	modport source(output valid, output conv_sum, output out_row, output out_col,
		output frame_last, input ready);
	modport sink(input valid, input conv_sum, input out_row, input out_col,
		input frame_last, output ready);
endinterface

// ===== hw/rtl/conv2d_valid_window_mac.sv =====
// Valid-mode 2D sliding-window multiply-accumulate (cross-correlation).
// item: valid/ready input channel. operation selects a coefficient load
// (coef_index, coef_value) or the next raster-order pixel (pixel_value).
// result: valid/ready output channel with conv_sum, out_row, out_col and
// frame_last on the last window of the frame.
// Configuration: cfg_we/cfg_index/cfg_data write img_width, img_height,
// kern_width, kern_height (indexes 0..3); any write restarts the frame.
// A coefficient load, or a pixel that completes no window, needs no MAC run.
// A pixel that completes a window starts a run and no item is taken until
// its result is loaded: one shared multiplier walks the window taps,
// reading one line-store word and one coefficient per cycle.
// The result sits in an output register; the next item is taken while it
// waits, but a further window result stalls until it has been transferred.
// Reset restores 1024x1024 image and 3x3 kernel, position row 0, column 0.
// Coefficient and line stores are not cleared; load coefficients first.
module conv2d_valid_window_mac #(
	parameter int MAX_WIDTH  = c2dmac_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL = c2dmac_pkg::MAX_KERNEL_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [c2dmac_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [c2dmac_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	c2dmac_in_if.sink                             item,
	c2dmac_out_if.source                          result
);

	c2dmac_pkg::cmd_t  cmd;
	c2dmac_pkg::stat_t stat;
	logic              in_ready;

	assign item.ready = in_ready;

	c2dmac_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.operation),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	c2dmac_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coef_index  (item.coef_index),
		.coef_value  (item.coef_value),
		.pixel_value (item.pixel_value),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result)
	);

endmodule

// ===== hw/rtl/c2dmac_ram.sv =====
module c2dmac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/c2dmac_ctl.sv =====
module c2dmac_ctl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  c2dmac_pkg::stat_t  stat,
	output c2dmac_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_FLUSH = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic [c2dmac_pkg::KDIM_BITS-1:0] ki_q, kj_q;
	logic row_end, win_end;

	assign row_end = (kj_q == stat.kw - 3'd1);
	assign win_end = (ki_q == stat.kh - 3'd1);

	always_comb begin
		cmd       = '0;
		in_ready  = (state_q == S_IDLE);
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (c2dmac_pkg::op_t'(in_op) == c2dmac_pkg::OP_PIXEL) begin
						cmd.pix_wr = 1'b1;
						if (stat.emit) begin
							cmd.init  = 1'b1;
							state_nxt = S_RUN;
						end
					end else begin
						cmd.coef_wr = 1'b1;
					end
				end
			end
			S_RUN: begin
				cmd.issue = 1'b1;
				if (row_end) begin
					cmd.next_row = 1'b1;
					if (win_end)
						state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!stat.busy)
					state_nxt = S_HOLD;
			end
			S_HOLD: begin
				// wait for the output register to free up
				if (!stat.out_blocked) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ki_q    <= '0;
			kj_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.init) begin
				ki_q <= '0;
				kj_q <= '0;
			end else if (cmd.issue) begin
				if (cmd.next_row) begin
					kj_q <= '0;
					ki_q <= ki_q + 3'd1;
				end else begin
					kj_q <= kj_q + 3'd1;
				end
			end
		end
	end

	a_emit_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> state_q == S_RUN)
		else $error("window start did not enter the MAC run");

	a_last_tap_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && row_end && win_end) |=> state_q == S_FLUSH)
		else $error("last tap did not end the run");

	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && !stat.busy) |=> state_q == S_HOLD)
		else $error("drained pipeline did not move to hold");

endmodule

// ===== hw/rtl/c2dmac_dp.sv =====
module c2dmac_dp #(
	parameter int MAX_WIDTH  = c2dmac_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL = c2dmac_pkg::MAX_KERNEL_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [c2dmac_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [c2dmac_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic [c2dmac_pkg::CIDX_BITS-1:0]           coef_index,
	input  logic signed [c2dmac_pkg::SAMPLE_BITS-1:0]  coef_value,
	input  logic signed [c2dmac_pkg::SAMPLE_BITS-1:0]  pixel_value,
	input  c2dmac_pkg::cmd_t                           cmd,
	output c2dmac_pkg::stat_t                          stat,
	c2dmac_out_if.source                               result
);

	localparam int SB         = c2dmac_pkg::SAMPLE_BITS;
	localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int LAW        = $clog2(LINE_DEPTH);
	localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int CAW        = COEF_DEPTH > 1 ? $clog2(COEF_DEPTH) : 1;
	localparam int SW         = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
	localparam int XW         = $clog2(MAX_WIDTH + 1);
	localparam int CW         = XW > c2dmac_pkg::DIM_BITS ? XW : c2dmac_pkg::DIM_BITS;
	localparam int TW         = SW + 4;
	localparam int RB         = c2dmac_pkg::ROW_BITS;
	localparam int DB         = c2dmac_pkg::DIM_BITS;
	localparam int KB         = c2dmac_pkg::KDIM_BITS;

	logic [DB-1:0] img_width_q, img_height_q;
	logic [KB-1:0] kern_width_q, kern_height_q;

	logic [XW-1:0] w;
	logic [DB-1:0] h;
	logic [KB-1:0] kw, kh;
	logic [CW-1:0] w_ext;

	logic [RB-1:0] row_q;
	logic [XW-1:0] col_q;
	logic [SW-1:0] slot_q;

	logic          bad;
	logic [RB-1:0] r;
	logic [XW-1:0] c;
	logic [SW-1:0] s;
	logic          emit, last;
	logic [RB-1:0] top;
	logic [XW-1:0] left;
	logic [TW-1:0] kh1, ts_w;
	logic [SW-1:0] ts;

	logic [LAW-1:0] waddr, raddr;
	logic [SW-1:0]  rslot_q;
	logic [LAW-1:0] rbase_q;
	logic [XW-1:0]  rcol_q, left_q;
	logic [CAW-1:0] cidx_q;
	logic [RB-1:0]  top_q;
	logic           last_q;

	logic [SB-1:0] pix_rd, coef_rd;
	logic          coef_we;
	logic          v1_s1, v2_s2;
	logic signed [2*SB-1:0] prod_s2;
	logic signed [c2dmac_pkg::SUM_BITS-1:0] acc_q;

	logic          out_valid_q;
	logic signed [c2dmac_pkg::SUM_BITS-1:0] sum_q;
	logic [RB-1:0] orow_q;
	logic [c2dmac_pkg::COL_OUT_BITS-1:0] ocol_q;
	logic          olast_q;

	// clamp the geometry registers
	always_comb begin
		w_ext = CW'(img_width_q);
		if (w_ext == '0)
			w = XW'(1);
		else if (w_ext > CW'(MAX_WIDTH))
			w = XW'(MAX_WIDTH);
		else
			w = XW'(w_ext);
		if (img_height_q == '0)
			h = DB'(1);
		else if (img_height_q > DB'(c2dmac_pkg::MAX_HEIGHT))
			h = DB'(c2dmac_pkg::MAX_HEIGHT);
		else
			h = img_height_q;
		if (kern_width_q == '0)
			kw = KB'(1);
		else if ({1'b0, kern_width_q} > 4'(MAX_KERNEL))
			kw = KB'(MAX_KERNEL);
		else
			kw = kern_width_q;
		if (kern_height_q == '0)
			kh = KB'(1);
		else if ({1'b0, kern_height_q} > 4'(MAX_KERNEL))
			kh = KB'(MAX_KERNEL);
		else
			kh = kern_height_q;
	end

	always_comb begin
		bad  = (col_q >= w) || ({1'b0, row_q} >= h);
		r    = bad ? '0 : row_q;
		c    = bad ? '0 : col_q;
		s    = bad ? '0 : slot_q;
		emit = ({1'b0, r} + DB'(1) >= DB'(kh)) && ({1'b0, c} + (XW+1)'(1) >= (XW+1)'(kw));
		last = ({1'b0, r} == h - DB'(1)) && (c == w - XW'(1));
		top  = RB'(r + RB'(1) - RB'(kh));
		left = XW'(c + XW'(1) - XW'(kw));
		// slot of the window's top row in the line ring
		kh1  = TW'(kh) - TW'(1);
		if (TW'(s) >= kh1)
			ts_w = TW'(s) - kh1;
		else
			ts_w = TW'(s) + TW'(MAX_KERNEL) - kh1;
		ts    = SW'(ts_w);
		waddr = LAW'(LAW'(s) * LAW'(MAX_WIDTH)) + LAW'(c);
		raddr = rbase_q + LAW'(rcol_q);
	end

	assign coef_we = cmd.coef_wr && ({2'b00, coef_index} < 8'(COEF_DEPTH));

	c2dmac_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (cmd.pix_wr),
		.waddr (waddr),
		.wdata (pixel_value),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (pix_rd)
	);

	c2dmac_ram #(.WIDTH(SB), .DEPTH(COEF_DEPTH)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (CAW'(coef_index)),
		.wdata (coef_value),
		.re    (cmd.issue),
		.raddr (cidx_q),
		.rdata (coef_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q   <= DB'(1024);
			img_height_q  <= DB'(1024);
			kern_width_q  <= KB'(3);
			kern_height_q <= KB'(3);
			row_q         <= '0;
			col_q         <= '0;
			slot_q        <= '0;
			v1_s1         <= 1'b0;
			v2_s2         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			v1_s1 <= cmd.issue;
			v2_s2 <= v1_s1;
			if (cfg_we) begin
				case (c2dmac_pkg::cfg_reg_t'(cfg_index))
					c2dmac_pkg::CFG_IMG_WIDTH:   img_width_q   <= cfg_data;
					c2dmac_pkg::CFG_IMG_HEIGHT:  img_height_q  <= cfg_data;
					c2dmac_pkg::CFG_KERN_WIDTH:  kern_width_q  <= cfg_data[KB-1:0];
					c2dmac_pkg::CFG_KERN_HEIGHT: kern_height_q <= cfg_data[KB-1:0];
					default: ;
				endcase
				// restart the frame
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else if (cmd.pix_wr) begin
				if ({1'b0, c} + (XW+1)'(1) >= {1'b0, w}) begin
					col_q <= '0;
					if ({1'b0, r} + DB'(1) >= h) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= r + RB'(1);
						slot_q <= (s == SW'(MAX_KERNEL - 1)) ? '0 : s + SW'(1);
					end
				end else begin
					col_q  <= c + XW'(1);
					row_q  <= r;
					slot_q <= s;
				end
			end
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			rslot_q <= ts;
			rbase_q <= LAW'(LAW'(ts) * LAW'(MAX_WIDTH));
			rcol_q  <= left;
			left_q  <= left;
			cidx_q  <= '0;
			top_q   <= top;
			last_q  <= last;
		end else if (cmd.issue) begin
			cidx_q <= cidx_q + CAW'(1);
			if (cmd.next_row) begin
				rcol_q <= left_q;
				if (rslot_q == SW'(MAX_KERNEL - 1)) begin
					rslot_q <= '0;
					rbase_q <= '0;
				end else begin
					rslot_q <= rslot_q + SW'(1);
					rbase_q <= rbase_q + LAW'(MAX_WIDTH);
				end
			end else begin
				rcol_q <= rcol_q + XW'(1);
			end
		end
		if (v1_s1)
			prod_s2 <= $signed(pix_rd) * $signed(coef_rd);
		if (cmd.init)
			acc_q <= '0;
		else if (v2_s2)
			acc_q <= acc_q + {{(c2dmac_pkg::SUM_BITS - 2*SB){prod_s2[2*SB-1]}}, prod_s2};
		if (cmd.load_out) begin
			sum_q   <= acc_q;
			orow_q  <= top_q;
			ocol_q  <= c2dmac_pkg::COL_OUT_BITS'(left_q);
			olast_q <= last_q;
		end
	end

	assign stat.emit        = emit;
	assign stat.busy        = v1_s1 | v2_s2;
	assign stat.out_blocked = out_valid_q && !result.ready;
	assign stat.kw          = kw;
	assign stat.kh          = kh;

	assign result.valid      = out_valid_q;
	assign result.conv_sum   = sum_q;
	assign result.out_row    = orow_q;
	assign result.out_col    = ocol_q;
	assign result.frame_last = olast_q;

	a_drained_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !v1_s1 && !v2_s2)
		else $error("result taken while products still in flight");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> acc_q == '0)
		else $error("accumulator not cleared at window start");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> result.valid && $stable(result.conv_sum))
		else $error("stalled result changed before transfer");

endmodule
